>>> design/adsr_pkg.sv
`default_nettype none

package adsr_pkg;

    // Field widths.
    localparam int LEVEL_W = 16;
    localparam int VEL_W   = 7;
    localparam int OP_W    = 2;
    localparam int CODE_W  = 3;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    // Full-scale peak before velocity scaling.
    localparam logic [LEVEL_W-1:0] PEAK_FULL_SCALE = 16'hFFFF;

    // Input operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } op_t;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_ATTACK_RATE   = 2'd0,
        REG_DECAY_RATE    = 2'd1,
        REG_SUSTAIN_LEVEL = 2'd2,
        REG_RELEASE_RATE  = 2'd3
    } reg_idx_t;

    localparam logic [CFG_W-1:0] ATTACK_RATE_RST   = 16'd66;
    localparam logic [CFG_W-1:0] DECAY_RATE_RST    = 16'd66;
    localparam logic [CFG_W-1:0] SUSTAIN_LEVEL_RST = 16'd52428;
    localparam logic [CFG_W-1:0] RELEASE_RATE_RST  = 16'd5;

    // Envelope stage, one-hot.
    typedef enum logic [4:0] {
        ST_ATTACK  = 5'b00001,
        ST_DECAY   = 5'b00010,
        ST_SUSTAIN = 5'b00100,
        ST_RELEASE = 5'b01000,
        ST_CLOSED  = 5'b10000
    } stage_t;

    // Stage codes as they appear on the result channel.
    localparam logic [CODE_W-1:0] CODE_ATTACK  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_DECAY   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_SUSTAIN = 3'd2;
    localparam logic [CODE_W-1:0] CODE_RELEASE = 3'd3;
    localparam logic [CODE_W-1:0] CODE_CLOSED  = 3'd4;

    typedef struct packed {
        logic [CFG_W-1:0] attack_rate;
        logic [CFG_W-1:0] decay_rate;
        logic [CFG_W-1:0] sustain_level;
        logic [CFG_W-1:0] release_rate;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        stage_t             stage;
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] held;
    } env_state_t;

    function automatic logic [CODE_W-1:0] stage_code(input stage_t st);
        logic [CODE_W-1:0] code;
        begin
            unique case (st)
                ST_ATTACK:  code = CODE_ATTACK;
                ST_DECAY:   code = CODE_DECAY;
                ST_SUSTAIN: code = CODE_SUSTAIN;
                ST_RELEASE: code = CODE_RELEASE;
                ST_CLOSED:  code = CODE_CLOSED;
                default:    code = CODE_CLOSED;
            endcase
            return code;
        end
    endfunction

endpackage

`default_nettype wire

>>> design/adsr_if.sv
`default_nettype none

// Command channel: one transaction is a tick, a note-on or a note-off.
interface adsr_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [adsr_pkg::OP_W-1:0]         operation;
    logic [adsr_pkg::VEL_W-1:0]        velocity;

    modport source (output valid, operation, velocity, input ready);
    modport sink   (input valid, operation, velocity, output ready);
endinterface

// Result channel: one transaction carries the level and stage after a command.
interface adsr_env_if;
    logic                              valid;
    logic                              ready;
    logic [adsr_pkg::LEVEL_W-1:0]      level;
    logic [adsr_pkg::CODE_W-1:0]       stage;

    modport source (output valid, level, stage, input ready);
    modport sink   (input valid, level, stage, output ready);
endinterface

`default_nettype wire

>>> design/adsr_step.sv
`default_nettype none

// Next envelope state for one command applied to the current state.
module adsr_step (
    input  wire adsr_pkg::cfg_t                 cfg,
    input  wire adsr_pkg::env_state_t           cur,
    input  wire logic [adsr_pkg::OP_W-1:0]      operation,
    input  wire logic [adsr_pkg::VEL_W-1:0]     velocity,
    output adsr_pkg::env_state_t                nxt
);

    localparam int PROD_W = adsr_pkg::LEVEL_W + adsr_pkg::VEL_W;

    logic [PROD_W-1:0]             peak_prod;
    logic [PROD_W-1:0]             held_prod;
    logic [adsr_pkg::LEVEL_W:0]    attack_sum;
    logic [adsr_pkg::LEVEL_W:0]    decay_floor;
    logic [adsr_pkg::LEVEL_W-1:0]  decay_diff;
    logic [adsr_pkg::LEVEL_W-1:0]  release_diff;

    // Velocity scaling: a 16 by 7 product, keeping bits above the velocity width.
    assign peak_prod = PROD_W'(adsr_pkg::PEAK_FULL_SCALE) * PROD_W'(velocity);
    assign held_prod = PROD_W'(cfg.sustain_level) * PROD_W'(velocity);

    // The decrement clamps when level - rate <= target, i.e. level <= target + rate.
    assign attack_sum   = {1'b0, cur.level} + {1'b0, cfg.attack_rate};
    assign decay_floor  = {1'b0, cur.held} + {1'b0, cfg.decay_rate};
    assign decay_diff   = cur.level - cfg.decay_rate;
    assign release_diff = cur.level - cfg.release_rate;

    always_comb
    begin
        nxt = cur;
        case (operation)
            adsr_pkg::OP_TICK:
            begin
                unique case (cur.stage)
                    adsr_pkg::ST_ATTACK:
                    begin
                        if (attack_sum >= {1'b0, cur.peak})
                        begin
                            nxt.level = cur.peak;
                            nxt.stage = adsr_pkg::ST_DECAY;
                        end
                        else
                        begin
                            nxt.level = attack_sum[adsr_pkg::LEVEL_W-1:0];
                        end
                    end
                    adsr_pkg::ST_DECAY:
                    begin
                        if ({1'b0, cur.level} <= decay_floor)
                        begin
                            nxt.level = cur.held;
                            nxt.stage = adsr_pkg::ST_SUSTAIN;
                        end
                        else
                        begin
                            nxt.level = decay_diff;
                        end
                    end
                    adsr_pkg::ST_RELEASE:
                    begin
                        if (cur.level <= cfg.release_rate)
                        begin
                            nxt.level = '0;
                            nxt.stage = adsr_pkg::ST_CLOSED;
                        end
                        else
                        begin
                            nxt.level = release_diff;
                        end
                    end
                    default:
                    begin
                        nxt = cur;
                    end
                endcase
            end
            adsr_pkg::OP_NOTE_ON:
            begin
                nxt.peak  = peak_prod[PROD_W-1:adsr_pkg::VEL_W];
                nxt.held  = held_prod[PROD_W-1:adsr_pkg::VEL_W];
                nxt.stage = adsr_pkg::ST_ATTACK;
            end
            adsr_pkg::OP_NOTE_OFF:
            begin
                nxt.peak  = '0;
                nxt.stage = adsr_pkg::ST_RELEASE;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/adsr_envelope_generator_top.sv
`default_nettype none

// Linear ADSR envelope generator. Each transaction on the cmd channel is a sample
// tick, a note-on with a 7-bit velocity, or a note-off, and produces exactly one
// transaction on the env channel with the 16-bit level and the stage code after
// that command (0 attack, 1 decay, 2 sustain, 3 release, 4 closed). A note-on
// scales the full-scale peak and the sustain register by velocity/128 and restarts
// attack from the present level; a note-off enters release. The block takes one
// command per clock cycle while the env channel is not stalled: a command is
// captured in an input register, and the next envelope state is computed from it
// and written to the state and result registers together once the result register
// can take it. The input register keeps accepting while a finished result waits
// on a stalled env channel, and the whole path only stops once both registers are
// full. The four rate and level registers are written through cfg_wen, cfg_index
// and cfg_data and should only be changed while no command is in flight.
module adsr_envelope_generator_top (
    input  wire                                 clk,
    input  wire                                 rst_n,
    adsr_cmd_if.sink                            cmd,
    adsr_env_if.source                          env,
    input  wire                                 cfg_wen,
    input  wire logic [adsr_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [adsr_pkg::CFG_W-1:0]     cfg_data
);

    adsr_pkg::cfg_t                    cfg_reg;
    adsr_pkg::env_state_t              state_reg;
    adsr_pkg::env_state_t              state_next;

    logic                              cmd_valid_reg;
    logic [adsr_pkg::OP_W-1:0]         cmd_op_reg;
    logic [adsr_pkg::VEL_W-1:0]        cmd_vel_reg;

    logic                              env_valid_reg;
    logic [adsr_pkg::LEVEL_W-1:0]      env_level_reg;
    logic [adsr_pkg::CODE_W-1:0]       env_stage_reg;

    logic                              advance;

    // The compute stage moves whenever the result register is free or being drained.
    assign advance   = !env_valid_reg || env.ready;
    assign cmd.ready = !cmd_valid_reg || advance;

    assign env.valid = env_valid_reg;
    assign env.level = env_level_reg;
    assign env.stage = env_stage_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_rate   <= adsr_pkg::ATTACK_RATE_RST;
            cfg_reg.decay_rate    <= adsr_pkg::DECAY_RATE_RST;
            cfg_reg.sustain_level <= adsr_pkg::SUSTAIN_LEVEL_RST;
            cfg_reg.release_rate  <= adsr_pkg::RELEASE_RATE_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                adsr_pkg::REG_ATTACK_RATE:   cfg_reg.attack_rate   <= cfg_data;
                adsr_pkg::REG_DECAY_RATE:    cfg_reg.decay_rate    <= cfg_data;
                adsr_pkg::REG_SUSTAIN_LEVEL: cfg_reg.sustain_level <= cfg_data;
                adsr_pkg::REG_RELEASE_RATE:  cfg_reg.release_rate  <= cfg_data;
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Input register: holds one accepted command until the compute stage takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_op_reg  <= cmd.operation;
            cmd_vel_reg <= cmd.velocity;
        end
    end

    adsr_step u_step (
        .cfg       (cfg_reg),
        .cur       (state_reg),
        .operation (cmd_op_reg),
        .velocity  (cmd_vel_reg),
        .nxt       (state_next)
    );

    // Envelope state is updated in the same edge that loads the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.level <= '0;
            state_reg.stage <= adsr_pkg::ST_ATTACK;
            state_reg.peak  <= '0;
            state_reg.held  <= '0;
        end
        else if (cmd_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            env_valid_reg <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg && advance)
        begin
            env_level_reg <= state_next.level;
            env_stage_reg <= adsr_pkg::stage_code(state_next.stage);
        end
    end

    // A closed envelope always rests at zero.
    a_closed_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.stage == adsr_pkg::ST_CLOSED) |-> (state_reg.level == '0))
        else $error("closed stage with nonzero level");

    // Sustain holds exactly the velocity-scaled sustain level.
    a_sustain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.stage == adsr_pkg::ST_SUSTAIN) |-> (state_reg.level == state_reg.held))
        else $error("sustain level differs from held sustain");

    // A command leaving the input register always lands in the result register.
    a_cmd_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && advance) |=> env_valid_reg)
        else $error("command lost between input and result registers");

    // Back-pressure reaches the command channel only when both registers are full.
    a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (cmd_valid_reg && env_valid_reg))
        else $error("command channel stalled with free storage");

    // The result copies the envelope state that was just written.
    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && advance) |=> (env_level_reg == state_reg.level))
        else $error("result level differs from envelope state");

endmodule

`default_nettype wire
